[rtl/srdb_pkg.sv]
// Package with shared types and constants of the stepper step generator.
package srdb_pkg;

  localparam int unsigned SPEED_W = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_DISABLE = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_ACCEL     = 3'd0,
    CFG_BL_COUNT  = 3'd1,
    CFG_BL_LIMIT  = 3'd2,
    CFG_BL_ACCEL2 = 3'd3,
    CFG_PH_SCALE  = 3'd4
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // Capture the request.
    logic sq_v;     // Square the speed magnitude.
    logic sq_e;     // Square the target magnitude.
    logic bl_prod;  // Form 2*A*s.
    logic ramp;     // Update speed.
    logic ph_mul;   // Multiply speed by phase scale.
    logic finish;   // Apply the request (phase and pulse on a tick), write the result.
  } srdb_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic backlash;
  } srdb_stat_t;

endpackage

[rtl/stepper_ramp_dds_backlash_top.sv]
// Set speed and disable go straight to finish; a tick runs ramp, phase multiply
// and finish, in backlash mode after the two squares and the stopping product,
// all formed in turn with the phase increment by one shared 32x32 multiplier.
// A result is held in an output register until taken; the next request is
// accepted as soon as the sequencer is back in idle.
module stepper_ramp_dds_backlash_top #(
  parameter int unsigned PENDING_LIMIT = 255,
  parameter int unsigned PHASE_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // opcode
  input  logic [31:0] s_axis_tdata,   // speed_cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // step, dir, enable, speed_now[31:0],
                                      // in_backlash, cmd_taken, zero pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import srdb_pkg::*;

  srdb_cmd_t  cmd;
  srdb_stat_t stat;
  logic [36:0] res;

  srdb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid), .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .stat_i(stat), .cmd_o(cmd)
  );

  srdb_dp #(.PENDING_LIMIT(PENDING_LIMIT), .PHASE_BITS(PHASE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .opcode_i(s_axis_tuser), .speed_cmd_i(s_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .result_o(res)
  );

  assign m_axis_tdata = {3'd0, res};
endmodule

[rtl/srdb_ctrl.sv]
// Sequencer that steps one request through the datapath.
module srdb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  srdb_pkg::srdb_stat_t stat_i,
  output srdb_pkg::srdb_cmd_t  cmd_o
);
  import srdb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQV, S_SQE, S_PROD, S_RAMP, S_PHMUL, S_FIN
  } state_e;

  state_e state_q;
  logic   ovalid_q;

  // The next request may enter while the last result waits, but the result
  // register is written only at finish, so finish waits for a free slot.
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = in_valid_i && (state_q == S_IDLE);
    cmd_o.sq_v    = (state_q == S_SQV);
    cmd_o.sq_e    = (state_q == S_SQE);
    cmd_o.bl_prod = (state_q == S_PROD);
    cmd_o.ramp    = (state_q == S_RAMP);
    cmd_o.ph_mul  = (state_q == S_PHMUL);
    cmd_o.finish  = (state_q == S_FIN) && (!ovalid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (out_ready_i) ovalid_q <= 1'b0;
      if (cmd_o.finish) ovalid_q <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (!stat_i.is_tick) state_q <= S_FIN;
            else if (stat_i.backlash) state_q <= S_SQV;
            else state_q <= S_RAMP;
          end
        end
        S_SQV:   state_q <= S_SQE;
        S_SQE:   state_q <= S_PROD;
        S_PROD:  state_q <= S_RAMP;
        S_RAMP:  state_q <= S_PHMUL;
        S_PHMUL: state_q <= S_FIN;
        S_FIN: begin
          if (cmd_o.finish) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o) else $error("finish did not raise valid");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sq_v, cmd_o.sq_e, cmd_o.bl_prod, cmd_o.ramp, cmd_o.ph_mul,
              cmd_o.finish})) else $error("overlapping commands");
endmodule

[rtl/srdb_dp.sv]
// Datapath: ramp, backlash limit, phase accumulator and step pulse logic.
module srdb_dp #(
  parameter int unsigned PENDING_LIMIT = 255,
  parameter int unsigned PHASE_BITS    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srdb_pkg::srdb_cmd_t  cmd_i,
  output srdb_pkg::srdb_stat_t stat_o,
  input  logic [1:0]           opcode_i,
  input  logic signed [31:0]   speed_cmd_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  output logic [36:0]          result_o
);
  import srdb_pkg::*;

  localparam int unsigned PW = 8;

  logic [30:0] accel_q, bl_limit_q;
  logic [15:0] bl_count_q;
  logic [14:0] bl_a2_q;
  logic [31:0] ph_scale_q;

  logic signed [31:0] speed_q, target_q;
  logic               mode_q, pulse_q, dir_q, en_q;
  logic [15:0]        bl_left_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [PW-1:0]      pend_q;
  logic [1:0]         op_q;
  logic signed [31:0] cmd_q;
  logic [63:0]        vsq_q, lsq_q;
  logic [63:0]        prod_q;
  logic [36:0]        res_q;

  assign stat_o.is_tick  = (opcode_e'(opcode_i) == OP_TICK);
  assign stat_o.backlash = mode_q;
  assign result_o = res_q;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Shared 32x32 multiplier.
  logic [31:0] ma, mb;
  logic [63:0] mp;
  always_comb begin
    ma = mag32(speed_q);
    mb = mag32(speed_q);
    if (cmd_i.sq_e) begin
      ma = mag32(target_q);
      mb = mag32(target_q);
    end else if (cmd_i.bl_prod) begin
      ma = {17'd0, bl_a2_q};
      mb = {16'd0, bl_left_q};
    end else if (cmd_i.ph_mul) begin
      mb = ph_scale_q;
    end
  end
  assign mp = ma * mb;

  // Ramp logic.
  logic signed [33:0] cur, tgt, a, lim, diff, n;
  logic [63:0] limsq;
  always_comb begin
    cur   = 34'(speed_q);
    tgt   = 34'(target_q);
    a     = {3'd0, accel_q};
    lim   = {3'd0, bl_limit_q};
    diff  = tgt - cur;
    limsq = lsq_q + {prod_q[39:0], 24'd0};
    if (!mode_q) begin
      if (diff > a) n = cur + a;
      else if (diff < -a) n = cur - a;
      else n = tgt;
    end else if (vsq_q < limsq) begin
      if (!cur[33]) begin
        n = cur + a;
        if (n > lim) n = lim;
      end else begin
        n = cur - a;
        if (n < -lim) n = -lim;
      end
    end else begin
      if (!cur[33]) begin
        n = cur - a;
        if (n < tgt) n = tgt;
      end else begin
        n = cur + a;
        if (n > tgt) n = tgt;
      end
    end
  end

  // Phase and pulse update.
  logic [PHASE_BITS:0]  psum;
  logic [PW-1:0]        pend_a;
  logic                 pulse_n, mode_n;
  logic [15:0]          left_n;
  logic [PW-1:0]        pend_n;
  logic [63:0]          inc_full;
  always_comb begin
    inc_full = prod_q >> 16;
    psum   = {1'b0, phase_q} + {1'b0, inc_full[PHASE_BITS-1:0]};
    pend_a = pend_q;
    if (psum[PHASE_BITS] && pend_q < PW'(PENDING_LIMIT)) pend_a = pend_q + 1'b1;
    pulse_n = pulse_q;
    pend_n  = pend_a;
    left_n  = bl_left_q;
    mode_n  = mode_q;
    if (!pulse_q && pend_a != '0) begin
      pulse_n = 1'b1;
    end else if (pulse_q) begin
      pulse_n = 1'b0;
      if (pend_a != '0) pend_n = pend_a - 1'b1;
      if (mode_q) begin
        if (bl_left_q != '0) left_n = bl_left_q - 1'b1;
        if (left_n == '0) mode_n = 1'b0;
      end
    end
  end

  logic ok, taken;
  assign ok = !mode_q || target_q == '0 || cmd_q == '0 || (target_q[31] == cmd_q[31]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= 31'd409; bl_count_q <= '0; bl_limit_q <= 31'd45875200;
      bl_a2_q <= 15'd16384; ph_scale_q <= 32'd268435;
      speed_q <= '0; target_q <= '0; mode_q <= 1'b0; bl_left_q <= '0;
      phase_q <= '0; pend_q <= '0; pulse_q <= 1'b0; dir_q <= 1'b1; en_q <= 1'b0;
      op_q <= OP_TICK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ACCEL:     accel_q    <= cfg_data_i[30:0];
          CFG_BL_COUNT:  bl_count_q <= cfg_data_i[15:0];
          CFG_BL_LIMIT:  bl_limit_q <= cfg_data_i[30:0];
          CFG_BL_ACCEL2: bl_a2_q    <= cfg_data_i[14:0];
          CFG_PH_SCALE:  ph_scale_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) op_q <= opcode_i;
      if (cmd_i.ramp) begin
        speed_q <= n[31:0];
        if (!mode_q) begin
          dir_q <= !n[31];
          if ((n[31] != speed_q[31]) && bl_count_q != '0) begin
            bl_left_q <= bl_count_q;
            mode_q    <= 1'b1;
          end
        end
      end
      if (cmd_i.finish) begin
        case (opcode_e'(op_q))
          OP_TICK: begin
            phase_q <= psum[PHASE_BITS-1:0];
            pend_q <= pend_n; pulse_q <= pulse_n;
            bl_left_q <= left_n; mode_q <= mode_n;
          end
          OP_SET: begin
            if (ok) target_q <= cmd_q;
            en_q <= 1'b1;
          end
          OP_DISABLE: en_q <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  assign taken = (opcode_e'(op_q) == OP_SET) && ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load)    cmd_q  <= speed_cmd_i;
    if (cmd_i.sq_v)    vsq_q  <= mp;
    if (cmd_i.sq_e)    lsq_q  <= mp;
    if (cmd_i.bl_prod || cmd_i.ph_mul) prod_q <= mp;
    if (cmd_i.finish) begin
      if (opcode_e'(op_q) == OP_TICK)
        res_q <= {1'b0, mode_n, speed_q, en_q, dir_q, pulse_n};
      else if (opcode_e'(op_q) == OP_SET)
        res_q <= {taken, mode_q, speed_q, 1'b1, dir_q, pulse_q};
      else if (opcode_e'(op_q) == OP_DISABLE)
        res_q <= {1'b0, mode_q, speed_q, 1'b0, dir_q, pulse_q};
      else
        res_q <= {1'b0, mode_q, speed_q, en_q, dir_q, pulse_q};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(PENDING_LIMIT)) else $error("pending count over limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulse_q && cmd_i.finish && opcode_e'(op_q) == OP_TICK) |=> !pulse_q)
    else $error("pulse held two ticks");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q && cmd_i.finish && opcode_e'(op_q) == OP_TICK && bl_left_q == 16'd0
     && pulse_q) |=> !mode_q) else $error("backlash did not end");
endmodule

[bench/stepper_ramp_dds_backlash_top_test.sv]
// Self-checking testbench for the stepper step generator with ramp, DDS and backlash.
module stepper_ramp_dds_backlash_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srdb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned QUEUE_MAX = 255;

  typedef struct packed {
    logic        cmd_taken;
    logic        in_backlash;
    logic [31:0] speed_now;
    logic        enable_level;
    logic        dir_level;
    logic        step_level;
  } motion_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = OP_TICK;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_ACCEL;
  logic [31:0] cfg_data_i = '0;

  stepper_ramp_dds_backlash_top DUT (.*);

  always #2 clk_i = ~clk_i;

  // Shadow copy of the configuration and state of the step generator.
  logic [30:0] accel_c;
  logic [15:0] blcount_c;
  logic [30:0] bllimit_c;
  logic [14:0] blaccel2_c;
  logic [31:0] scale_c;
  logic signed [31:0] speed_m, target_m;
  logic        backlash_m;
  logic [15:0] bl_left_m;
  logic [31:0] phase_m;
  int unsigned pending_m;
  logic        pulse_m, dir_m, enable_m;

  motion_res_t motion_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cnt = 0;
  bit          hold_go = 1'b0;

  function automatic longint unsigned magnitude(logic signed [31:0] v);
    return (v < 0) ? longint'(-longint'(v)) : longint'(v);
  endfunction

  function automatic void ramp_normal_model();
    longint a, cur, diff;
    logic was_neg;
    a = longint'(accel_c);
    cur = longint'(speed_m);
    diff = longint'(target_m) - cur;
    was_neg = speed_m < 0;
    if (diff > a) cur = cur + a;
    else if (diff < -a) cur = cur - a;
    else cur = longint'(target_m);
    speed_m = cur[31:0];
    dir_m = !(speed_m < 0);
    if ((speed_m < 0) != was_neg && blcount_c != 0) begin
      bl_left_m = blcount_c;
      backlash_m = 1'b1;
    end
  endfunction

  // In backlash the speed may only rise while v^2 < vend^2 + 2*A*s (all in Q32.32).
  function automatic void ramp_backlash_model();
    longint a, lim, cur, tgt, n;
    longint unsigned vm, em, v_sq, lim_sq;
    a = longint'(accel_c);
    lim = longint'(bllimit_c);
    cur = longint'(speed_m);
    tgt = longint'(target_m);
    vm = magnitude(speed_m);
    em = magnitude(target_m);
    v_sq = vm * vm;
    lim_sq = em * em + ((longint'(blaccel2_c) * longint'(bl_left_m)) << 24);
    if (v_sq < lim_sq) begin
      if (cur >= 0) begin
        n = cur + a;
        if (n > lim) n = lim;
      end else begin
        n = cur - a;
        if (n < -lim) n = -lim;
      end
    end else begin
      if (cur >= 0) begin
        n = cur - a;
        if (n < tgt) n = tgt;
      end else begin
        n = cur + a;
        if (n > tgt) n = tgt;
      end
    end
    speed_m = n[31:0];
  endfunction

  function automatic void tick_model();
    longint unsigned inc, sum;
    if (!backlash_m) ramp_normal_model();
    else ramp_backlash_model();
    inc = ((magnitude(speed_m) * longint'(scale_c)) >> 16) & 64'hFFFF_FFFF;
    sum = longint'(phase_m) + inc;
    phase_m = sum[31:0];
    if (sum > 64'hFFFF_FFFF && pending_m < QUEUE_MAX) pending_m++;
    if (!pulse_m && pending_m != 0) begin
      pulse_m = 1'b1;
    end else if (pulse_m) begin
      pulse_m = 1'b0;
      if (pending_m != 0) pending_m--;
      if (backlash_m) begin
        if (bl_left_m != 0) bl_left_m--;
        if (bl_left_m == 0) backlash_m = 1'b0;
      end
    end
  endfunction

  function automatic motion_res_t step_motion(opcode_e op, logic signed [31:0] cmd);
    motion_res_t r;
    logic taken;
    taken = 1'b0;
    case (op)
      OP_TICK: tick_model();
      OP_SET: begin
        if (!backlash_m || target_m == 0 || cmd == 0 || ((target_m < 0) == (cmd < 0))) begin
          target_m = cmd;
          taken = 1'b1;
        end
        enable_m = 1'b1;
      end
      OP_DISABLE: enable_m = 1'b0;
      default: ;
    endcase
    r.step_level = pulse_m;
    r.dir_level = dir_m;
    r.enable_level = enable_m;
    r.speed_now = speed_m;
    r.in_backlash = backlash_m;
    r.cmd_taken = taken;
    return r;
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    motion_res_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[36:0];
      if (motion_q.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        exp_r = motion_q.pop_front();
        if (got.step_level !== exp_r.step_level)
          report($sformatf("step %b, want %b", got.step_level, exp_r.step_level));
        if (got.dir_level !== exp_r.dir_level)
          report($sformatf("dir %b, want %b", got.dir_level, exp_r.dir_level));
        if (got.enable_level !== exp_r.enable_level)
          report($sformatf("enable %b, want %b", got.enable_level, exp_r.enable_level));
        if (got.speed_now !== exp_r.speed_now)
          report($sformatf("speed %h, want %h", got.speed_now, exp_r.speed_now));
        if (got.in_backlash !== exp_r.in_backlash)
          report($sformatf("backlash %b, want %b", got.in_backlash, exp_r.in_backlash));
        if (got.cmd_taken !== exp_r.cmd_taken)
          report($sformatf("cmd_taken %b, want %b", got.cmd_taken, exp_r.cmd_taken));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", motion_q.size());
      $display("[stepper_ramp_dds_backlash_top] ERROR");
      $finish;
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always begin
    wait (hold_go);
    hold_cnt = 1500;
    while (hold_cnt > 0) begin
      @(negedge clk_i);
      hold_cnt--;
    end
    hold_go = 1'b0;
  end

  always @(negedge clk_i)
    m_axis_tready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);

  task automatic send_request(opcode_e op, logic [31:0] cmd);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    motion_q.push_back(step_motion(op, cmd));
    @(negedge clk_i);
  endtask

  // Waits for every result, then lets the sequencer settle before a register write.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (motion_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CFG_ACCEL: accel_c = val[30:0];
      CFG_BL_COUNT: blcount_c = val[15:0];
      CFG_BL_LIMIT: bllimit_c = val[30:0];
      CFG_BL_ACCEL2: blaccel2_c = val[14:0];
      default: scale_c = val;
    endcase
  endtask

  task automatic write_all(logic [31:0] acc, logic [31:0] cnt, logic [31:0] lim,
                           logic [31:0] acc2, logic [31:0] scl);
    write_reg(CFG_ACCEL, acc);
    write_reg(CFG_BL_COUNT, cnt);
    write_reg(CFG_BL_LIMIT, lim);
    write_reg(CFG_BL_ACCEL2, acc2);
    write_reg(CFG_PH_SCALE, scl);
  endtask

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3, 4: return $urandom_range(1, 400000);
      5, 6: return -$urandom_range(1, 400000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    write_all(32'h7FFF_FFFF, 3, 45875200, 16384, 32'hFFFF_FFFF);
    send_request(OP_NONE, 32'hFFFF_FFFF);
    send_request(OP_TICK, '0);
    send_request(OP_SET, 32'h7FFF_FFFF);
    repeat (2) send_request(OP_TICK, '0);
    send_request(OP_SET, 32'h8000_0000);
    // The first tick brings the speed to zero, the second reverses it.
    repeat (2) send_request(OP_TICK, '0);
    // Opposite sign is refused in backlash; zero and same sign are taken.
    send_request(OP_SET, 32'h0001_0000);
    send_request(OP_SET, '0);
    send_request(OP_SET, 32'hFFFF_0000);
    repeat (6) send_request(OP_TICK, '0);
    send_request(OP_DISABLE, '0);
    repeat (2) send_request(OP_TICK, '0);
    drain();
    // A reversal with no backlash steps stays in normal mode.
    write_reg(CFG_BL_COUNT, 0);
    send_request(OP_SET, 32'h0002_0000);
    repeat (3) send_request(OP_TICK, '0);
    drain();
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned k;
    for (int unsigned i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 15) send_request(OP_SET, pick_speed());
      else if (k < 19) send_request(OP_DISABLE, $urandom);
      else if (k < 22) send_request(OP_NONE, $urandom);
      else send_request(OP_TICK, $urandom);
    end
  endtask

  task automatic test_random_phase(int unsigned idle, int unsigned stall, int unsigned n);
    drain();
    idle_pct = idle;
    stall_pct = stall;
    case ($urandom_range(3))
      0: write_all(32'h7FFF_FFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF, 32'hFFFF_FFFF);
      1: write_all(0, 0, 0, 0, 0);
      default: write_all($urandom_range(1, 300000), $urandom_range(1, 24),
                         $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF),
                         $urandom);
    endcase
    random_traffic(n);
  endtask

  task automatic test_pressure();
    drain();
    idle_pct = 0;
    stall_pct = 0;
    write_all(32'h0100_0000, 5, 32'h4000_0000, 32'h0100, 32'h8000_0000);
    hold_go = 1'b1;
    random_traffic(60);
  endtask

  initial begin
    accel_c = 409;
    blcount_c = 0;
    bllimit_c = 45875200;
    blaccel2_c = 16384;
    scale_c = 268435;
    speed_m = 0;
    target_m = 0;
    backlash_m = 1'b0;
    bl_left_m = 0;
    phase_m = 0;
    pending_m = 0;
    pulse_m = 1'b0;
    dir_m = 1'b1;
    enable_m = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_phase(0, 0, 420);
    test_random_phase(77, 0, 420);
    test_random_phase(0, 77, 420);
    test_random_phase(38, 38, 420);
    test_random_phase(0, 0, 100);
    test_pressure();
    drain();
    if (errors == 0) begin
      $display("[stepper_ramp_dds_backlash_top] OK");
    end else begin
      $display("[stepper_ramp_dds_backlash_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/srdb_pkg.sv
rtl/srdb_ctrl.sv
rtl/srdb_dp.sv
rtl/stepper_ramp_dds_backlash_top.sv
bench/stepper_ramp_dds_backlash_top_test.sv
